[sv/closest_point_on_segment_3d_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the closest-point unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_3D_UNIT_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_3D_UNIT_ASSERT_SVH

// same-cycle implication
`define CPOS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpos check failed");

// next-cycle implication
`define CPOS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpos check failed");

`endif

[sv/cpos_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpos_pkg
// Types and widths shared by the closest-point-on-segment unit.
// ----------------------------------------------------------------------------
package cpos_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int DIFF_W      = COORD_WIDTH + 1;     // B-A, P-A
	localparam int PROD_W      = 2 * DIFF_W;          // one signed product
	localparam int NUM_W       = PROD_W + 2;          // sum of three products
	localparam int DEN_W       = 2 * COORD_WIDTH + 2; // |B-A|^2
	localparam int MAG_W       = NUM_W - 1;           // |num|
	localparam int DMAG_W      = COORD_WIDTH;         // |B-A| per axis
	localparam int LO_W        = (MAG_W + 1) / 2;     // low split of |num|
	localparam int HI_W        = MAG_W - LO_W;
	localparam int N_W         = MAG_W + DMAG_W;      // dividend
	localparam int REM_W       = N_W + 1;
	localparam int QB          = COORD_WIDTH + 2;     // quotient bits, msb = saturate
	localparam int SUM_W       = QB + 1;
	localparam int NUM_REGS    = 6;
	localparam int CFG_IDX_W   = 3;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X   = 3'd3,
		REG_END_Y   = 3'd4,
		REG_END_Z   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] query_x;
		logic signed [COORD_WIDTH-1:0] query_y;
		logic signed [COORD_WIDTH-1:0] query_z;
	} query_t;

	typedef struct packed {
		logic                          on_segment;
		logic signed [COORD_WIDTH-1:0] near_x;
		logic signed [COORD_WIDTH-1:0] near_y;
		logic signed [COORD_WIDTH-1:0] near_z;
	} result_t;

	// per-request data that rides alongside the divider
	typedef struct packed {
		logic                        degen;
		logic                        on_seg;
		logic [2:0]                  neg;
		logic [2:0][COORD_WIDTH-1:0] a;
	} side_t;

endpackage

[sv/cpos_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpos_div
// Pipelined restoring divider, one quotient bit per stage. The top
// quotient bit flags a quotient too large for the coordinate range.
// ----------------------------------------------------------------------------
module cpos_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cpos_pkg::N_W-1:0]     num,
	input  logic [cpos_pkg::DEN_W-1:0]   den,
	output logic [cpos_pkg::QB-1:0]      quo
);

	logic [cpos_pkg::REM_W-1:0] rem_s [cpos_pkg::QB];
	logic [cpos_pkg::DEN_W-1:0] den_s [cpos_pkg::QB];
	logic [cpos_pkg::QB-1:0]    quo_s [cpos_pkg::QB];

	for (genvar k = 0; k < cpos_pkg::QB; k++) begin : g_step
		logic [cpos_pkg::REM_W-1:0] rin;
		logic [cpos_pkg::DEN_W-1:0] din;
		logic [cpos_pkg::QB-1:0]    qin;
		logic [cpos_pkg::REM_W-1:0] dsh;
		logic [cpos_pkg::REM_W:0]   diff;

		if (k == 0) begin : g_first
			assign rin = cpos_pkg::REM_W'(num);
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = den_s[k-1];
			assign qin = quo_s[k-1];
		end

		assign dsh  = cpos_pkg::REM_W'(din) << (cpos_pkg::QB - 1 - k);
		assign diff = {1'b0, rin} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= diff[cpos_pkg::REM_W] ? rin : diff[cpos_pkg::REM_W-1:0];
				den_s[k] <= din;
				quo_s[k] <= qin | (diff[cpos_pkg::REM_W] ? '0 :
					(cpos_pkg::QB'(1) << (cpos_pkg::QB - 1 - k)));
			end
		end
	end

	assign quo = quo_s[cpos_pkg::QB-1];

endmodule

[sv/closest_point_on_segment_3d_unit.sv]
`timescale 1ns / 1ps
// Pipeline: 6 arithmetic stages, 26 divider stages, 1 output register.
// Throughput: one request per cycle; the whole pipe advances together and
//   freezes while the output register holds an unaccepted result.
// Reset: arst_n clears all valid bits and the six segment registers to 0.
// ----------------------------------------------------------------------------
// closest_point_on_segment_3d_unit
// Projects each query point onto the line through a configured segment A-B,
// saturating the result and flagging a projection ratio in (0,1].
// ----------------------------------------------------------------------------
module closest_point_on_segment_3d_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [cpos_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpos_pkg::COORD_WIDTH-1:0]    cfg_data,
	// request in
	input  logic                                in_valid,
	output logic                                in_stall,
	input  cpos_pkg::query_t                    query,
	// result out
	output logic                                out_valid,
	input  logic                                out_stall,
	output cpos_pkg::result_t                   result
);

	localparam int CW = cpos_pkg::COORD_WIDTH;
	localparam int QB = cpos_pkg::QB;

	// ---------------------------------------------------------------------
	// Segment registers
	// ---------------------------------------------------------------------
	logic signed [CW-1:0] cfg_q [cpos_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cpos_pkg::NUM_REGS; i++) cfg_q[i] <= '0;
		end else if (cfg_we) begin
			case (cpos_pkg::cfg_reg_t'(cfg_index))
				cpos_pkg::REG_START_X: cfg_q[cpos_pkg::REG_START_X] <= cfg_data;
				cpos_pkg::REG_START_Y: cfg_q[cpos_pkg::REG_START_Y] <= cfg_data;
				cpos_pkg::REG_START_Z: cfg_q[cpos_pkg::REG_START_Z] <= cfg_data;
				cpos_pkg::REG_END_X:   cfg_q[cpos_pkg::REG_END_X]   <= cfg_data;
				cpos_pkg::REG_END_Y:   cfg_q[cpos_pkg::REG_END_Y]   <= cfg_data;
				cpos_pkg::REG_END_Z:   cfg_q[cpos_pkg::REG_END_Z]   <= cfg_data;
				default: ; // out-of-range index: ignored
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Global advance: the pipe moves whenever the output slot is free or
	// being taken. No bubble squeezing; every stage holds on a stall.
	// ---------------------------------------------------------------------
	logic adv;
	logic out_degen_q;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic signed [CW-1:0] qc [3];
	assign qc[0] = query.query_x;
	assign qc[1] = query.query_y;
	assign qc[2] = query.query_z;

	// ---------------------------------------------------------------------
	// s1: differences d = B-A, e = P-A
	// ---------------------------------------------------------------------
	logic                               vld_s1;
	logic signed [cpos_pkg::DIFF_W-1:0] d_s1 [3];
	logic signed [cpos_pkg::DIFF_W-1:0] e_s1 [3];
	logic [2:0][CW-1:0]                 a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= cfg_q[i];
				d_s1[i] <= cpos_pkg::DIFF_W'(cfg_q[3+i]) - cpos_pkg::DIFF_W'(cfg_q[i]);
				e_s1[i] <= cpos_pkg::DIFF_W'(qc[i]) - cpos_pkg::DIFF_W'(cfg_q[i]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// s2: products d*e and d*d, |d| and its sign
	// ---------------------------------------------------------------------
	logic                               vld_s2;
	logic signed [cpos_pkg::PROD_W-1:0] pn_s2 [3];
	logic signed [cpos_pkg::PROD_W-1:0] pd_s2 [3];
	logic [cpos_pkg::DMAG_W-1:0]        dmag_s2 [3];
	logic [2:0]                         dneg_s2;
	logic [2:0][CW-1:0]                 a_s2;
	logic signed [cpos_pkg::DIFF_W-1:0] dabs_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dabs_c[i] = d_s1[i][cpos_pkg::DIFF_W-1] ? -d_s1[i] : d_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= a_s1;
			for (int i = 0; i < 3; i++) begin
				pn_s2[i]   <= d_s1[i] * e_s1[i];
				pd_s2[i]   <= d_s1[i] * d_s1[i];
				dmag_s2[i] <= cpos_pkg::DMAG_W'(dabs_c[i]);
				dneg_s2[i] <= d_s1[i][cpos_pkg::DIFF_W-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// s3: num and den sums
	// ---------------------------------------------------------------------
	logic                              vld_s3;
	logic signed [cpos_pkg::NUM_W-1:0] num_s3;
	logic [cpos_pkg::DEN_W-1:0]        den_s3;
	logic [cpos_pkg::DMAG_W-1:0]       dmag_s3 [3];
	logic [2:0]                        dneg_s3;
	logic [2:0][CW-1:0]                a_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3  <= cpos_pkg::NUM_W'(pn_s2[0]) + cpos_pkg::NUM_W'(pn_s2[1])
				+ cpos_pkg::NUM_W'(pn_s2[2]);
			den_s3  <= cpos_pkg::DEN_W'(pd_s2[0]) + cpos_pkg::DEN_W'(pd_s2[1])
				+ cpos_pkg::DEN_W'(pd_s2[2]);
			dmag_s3 <= dmag_s2;
			dneg_s3 <= dneg_s2;
			a_s3    <= a_s2;
		end
	end

	// ---------------------------------------------------------------------
	// s4: |num|, on-segment flag, degenerate check, result signs
	// ---------------------------------------------------------------------
	logic                              vld_s4;
	logic [cpos_pkg::MAG_W-1:0]        nm_s4;
	logic [cpos_pkg::DEN_W-1:0]        den_s4;
	logic [cpos_pkg::DMAG_W-1:0]       dmag_s4 [3];
	cpos_pkg::side_t                   side_s4;
	logic                              nneg_c;
	logic signed [cpos_pkg::NUM_W-1:0] nabs_c;

	assign nneg_c = num_s3[cpos_pkg::NUM_W-1];
	assign nabs_c = nneg_c ? -num_s3 : num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s4          <= cpos_pkg::MAG_W'(nabs_c);
			den_s4         <= den_s3;
			dmag_s4        <= dmag_s3;
			side_s4.degen  <= (den_s3 == '0);
			side_s4.on_seg <= !nneg_c && (num_s3 != '0)
				&& ($unsigned(num_s3) <= cpos_pkg::NUM_W'(den_s3));
			side_s4.neg    <= dneg_s3 ^ {3{nneg_c}};
			side_s4.a      <= a_s3;
		end
	end

	// ---------------------------------------------------------------------
	// s5: |num| * |d_i| as two partial products per axis
	// ---------------------------------------------------------------------
	logic                                             vld_s5;
	logic [cpos_pkg::LO_W+cpos_pkg::DMAG_W-1:0]       plo_s5 [3];
	logic [cpos_pkg::HI_W+cpos_pkg::DMAG_W-1:0]       phi_s5 [3];
	logic [cpos_pkg::DEN_W-1:0]                       den_s5;
	cpos_pkg::side_t                                  side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				plo_s5[i] <= nm_s4[cpos_pkg::LO_W-1:0] * dmag_s4[i];
				phi_s5[i] <= nm_s4[cpos_pkg::MAG_W-1:cpos_pkg::LO_W] * dmag_s4[i];
			end
			den_s5  <= den_s4;
			side_s5 <= side_s4;
		end
	end

	// ---------------------------------------------------------------------
	// s6: combine partial products into the dividend
	// ---------------------------------------------------------------------
	logic                       vld_s6;
	logic [cpos_pkg::N_W-1:0]   n_s6 [3];
	logic [cpos_pkg::DEN_W-1:0] den_s6;
	cpos_pkg::side_t            side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s6[i] <= (cpos_pkg::N_W'(phi_s5[i]) << cpos_pkg::LO_W)
					+ cpos_pkg::N_W'(plo_s5[i]);
			end
			den_s6  <= den_s5;
			side_s6 <= side_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Divider pipes, one per axis, with side data shifted in step
	// ---------------------------------------------------------------------
	logic [QB-1:0]   quo [3];
	logic            vld_dv  [QB];
	cpos_pkg::side_t side_dv [QB];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		cpos_div u_div (
			.clk (clk),
			.en  (adv),
			.num (n_s6[i]),
			.den (den_s6),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++) vld_dv[k] <= 1'b0;
		end else if (adv) begin
			vld_dv[0] <= vld_s6;
			for (int k = 1; k < QB; k++) vld_dv[k] <= vld_dv[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dv[0] <= side_s6;
			for (int k = 1; k < QB; k++) side_dv[k] <= side_dv[k-1];
		end
	end

	// ---------------------------------------------------------------------
	// Final: A + signed quotient, saturate; degenerate segment returns A
	// ---------------------------------------------------------------------
	cpos_pkg::side_t                   sd;
	logic signed [cpos_pkg::SUM_W-1:0] qs_c  [3];
	logic signed [cpos_pkg::SUM_W-1:0] sum_c [3];
	logic signed [CW-1:0]              near_c [3];
	cpos_pkg::result_t                 res_c;

	assign sd = side_dv[QB-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs_c[i]  = signed'(cpos_pkg::SUM_W'(quo[i][QB-2:0]));
			sum_c[i] = cpos_pkg::SUM_W'(signed'(sd.a[i]))
				+ (sd.neg[i] ? -qs_c[i] : qs_c[i]);
			if (sd.degen) begin
				near_c[i] = signed'(sd.a[i]);
			end else if (quo[i][QB-1]) begin
				// quotient beyond the coordinate range
				near_c[i] = sd.neg[i] ? cpos_pkg::COORD_MIN : cpos_pkg::COORD_MAX;
			end else if (sum_c[i] > cpos_pkg::SUM_W'(cpos_pkg::COORD_MAX)) begin
				near_c[i] = cpos_pkg::COORD_MAX;
			end else if (sum_c[i] < cpos_pkg::SUM_W'(cpos_pkg::COORD_MIN)) begin
				near_c[i] = cpos_pkg::COORD_MIN;
			end else begin
				near_c[i] = CW'(sum_c[i]);
			end
		end
		res_c.on_segment = sd.on_seg && !sd.degen;
		res_c.near_x     = near_c[0];
		res_c.near_y     = near_c[1];
		res_c.near_z     = near_c[2];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_dv[QB-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result      <= res_c;
			out_degen_q <= sd.degen;
		end
	end

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
`include "closest_point_on_segment_3d_unit_assert.svh"

	// a held result must back-pressure the input
	`CPOS_ASSERT_IMPL(a_stall_back, out_valid && out_stall, in_stall)
	// a degenerate segment never reports on-segment
	`CPOS_ASSERT_IMPL(a_degen_flag, out_valid && out_degen_q, !result.on_segment)
	// while stalled, the s1 and s6 valid bits freeze
	`CPOS_ASSERT_NEXT(a_freeze, in_stall, $stable(vld_s1) && $stable(vld_s6))

endmodule
